>>> sv/dsu_pkg.sv
`timescale 1ns / 1ps

package dsu_pkg;

   localparam logic [7:0] SEQ_TAG = 8'h30;
   localparam logic [7:0] INT_TAG = 8'h02;
   localparam logic [7:0] SEQ_HDR_LEN = 8'h02;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_RAW   = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [6:0] {
      PH_IDLE     = 7'b0000001,
      PH_SEQ_LEN  = 7'b0000010,
      PH_INT_TAG  = 7'b0000100,
      PH_INT_LEN  = 7'b0001000,
      PH_SKIP     = 7'b0010000,
      PH_DATA     = 7'b0100000,
      PH_FINISHED = 7'b1000000
   } phase_type;

   typedef struct packed {
      kind_type   result_kind;
      logic [7:0] raw_byte;
      logic [7:0] raw_count;
      logic       is_last;
   } result_type;

endpackage

>>> sv/dsu_channels.sv
`timescale 1ns / 1ps

interface dsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_signature;
   logic [7:0] sig_length;

   modport source (output valid, output data_byte, output first_of_signature,
                   output sig_length, input ready);
   modport sink (input valid, input data_byte, input first_of_signature,
                 input sig_length, output ready);
endinterface

interface dsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] raw_byte;
   logic [7:0] raw_count;
   logic       is_last;

   modport source (output valid, output result_kind, output raw_byte,
                   output raw_count, output is_last, input ready);
   modport sink (input valid, input result_kind, input raw_byte,
                 input raw_count, input is_last, output ready);
endinterface

>>> sv/der_ecdsa_signature_unpacker_top.sv
`timescale 1ns / 1ps
// The req_chan channel takes one byte of a DER-encoded ECDSA signature per item;
// first_of_signature marks the sequence tag and carries the total length in
// sig_length. The rsp_chan channel returns the r and s bytes as raw items, then
// one done item with the raw byte count, or one error item on a tag, length or
// size mismatch. Framing bytes and bytes after the end give no item.
// Each accepted byte is parsed in the cycle it is accepted and its results
// are written into a four-entry result queue, so the first result is
// visible in the cycle after acceptance. One byte is accepted per cycle
// while req_chan.ready is high; the last byte of s gives two items, and
// the queue absorbs the extra one. req_chan.ready is high while the queue
// has room for two items. When the receiver stalls, bytes are still taken
// until the queue holds three or four items, and then the input stalls too;
// no item is lost or repeated. A synchronous reset empties the queue and
// returns the parser to waiting for a first byte.
module der_ecdsa_signature_unpacker_top #(
   parameter int RAW_MAX = 128
) (
   input logic    clock,
   input logic    reset,
   dsu_req_if.sink   req_chan,
   dsu_rsp_if.source rsp_chan
);
   import dsu_pkg::*;

   phase_type  parse_phase_ff, parse_phase_in;
   logic [7:0] held_total_length_ff, held_total_length_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] emitted_count_ff, emitted_count_in;
   logic       integer_index_ff, integer_index_in;

   result_type queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;

   logic       accept, pop, finish;
   logic [1:0] n_push;
   result_type res0, res1;
   logic [7:0] len;
   logic [8:0] len_sum;
   logic [7:0] bytes_dec;
   logic [QUEUE_PTR_W-1:0] wr_ptr_nxt;

   assign accept = req_chan.valid && req_chan.ready;
   assign pop = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);

   assign rsp_chan.valid = count_ff != '0;
   assign rsp_chan.result_kind = queue_ff[rd_ptr_ff].result_kind;
   assign rsp_chan.raw_byte = queue_ff[rd_ptr_ff].raw_byte;
   assign rsp_chan.raw_count = queue_ff[rd_ptr_ff].raw_count;
   assign rsp_chan.is_last = queue_ff[rd_ptr_ff].is_last;

   assign len = {req_chan.data_byte[7:1], 1'b0};
   assign len_sum = {1'b0, emitted_count_ff} + {1'b0, len};
   assign bytes_dec = bytes_left_ff - 8'd1;
   assign wr_ptr_nxt = wr_ptr_ff + QUEUE_PTR_W'(1);

   always_comb begin
      parse_phase_in = parse_phase_ff;
      held_total_length_in = held_total_length_ff;
      bytes_left_in = bytes_left_ff;
      emitted_count_in = emitted_count_ff;
      integer_index_in = integer_index_ff;
      finish = 1'b0;
      n_push = 2'd0;
      res0 = '{result_kind: KIND_ERROR, raw_byte: 8'd0,
               raw_count: emitted_count_ff, is_last: 1'b1};
      res1 = '{result_kind: KIND_DONE, raw_byte: 8'd0,
               raw_count: emitted_count_ff, is_last: 1'b1};
      if (accept) begin
         if (req_chan.first_of_signature) begin
            held_total_length_in = req_chan.sig_length;
            bytes_left_in = 8'd0;
            emitted_count_in = 8'd0;
            integer_index_in = 1'b0;
            res0.raw_count = 8'd0;
            if (req_chan.data_byte != SEQ_TAG) begin
               parse_phase_in = PH_FINISHED;
               n_push = 2'd1;
            end else begin
               parse_phase_in = PH_SEQ_LEN;
            end
         end else begin
            case (parse_phase_ff)
               PH_SEQ_LEN: begin
                  if (held_total_length_ff < SEQ_HDR_LEN ||
                      req_chan.data_byte != held_total_length_ff - SEQ_HDR_LEN) begin
                     parse_phase_in = PH_FINISHED;
                     n_push = 2'd1;
                  end else begin
                     parse_phase_in = PH_INT_TAG;
                  end
               end
               PH_INT_TAG: begin
                  if (req_chan.data_byte != INT_TAG) begin
                     parse_phase_in = PH_FINISHED;
                     n_push = 2'd1;
                  end else begin
                     parse_phase_in = PH_INT_LEN;
                  end
               end
               PH_INT_LEN: begin
                  if (len_sum > 9'(RAW_MAX)) begin
                     parse_phase_in = PH_FINISHED;
                     n_push = 2'd1;
                  end else begin
                     bytes_left_in = len;
                     if (req_chan.data_byte[0]) begin
                        parse_phase_in = PH_SKIP;
                     end else if (len == 8'd0) begin
                        finish = 1'b1;
                     end else begin
                        parse_phase_in = PH_DATA;
                     end
                  end
               end
               PH_SKIP: begin
                  if (bytes_left_ff == 8'd0) begin
                     finish = 1'b1;
                  end else begin
                     parse_phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  emitted_count_in = emitted_count_ff + 8'd1;
                  bytes_left_in = bytes_dec;
                  res0 = '{result_kind: KIND_RAW, raw_byte: req_chan.data_byte,
                           raw_count: emitted_count_in, is_last: 1'b0};
                  n_push = 2'd1;
                  finish = bytes_dec == 8'd0;
               end
               default: begin
               end
            endcase
            if (finish) begin
               if (!integer_index_ff) begin
                  integer_index_in = 1'b1;
                  parse_phase_in = PH_INT_TAG;
               end else begin
                  parse_phase_in = PH_FINISHED;
                  res1.raw_count = emitted_count_in;
                  if (n_push == 2'd0) begin
                     res0 = res1;
                     n_push = 2'd1;
                  end else begin
                     n_push = 2'd2;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_phase_ff <= PH_IDLE;
         held_total_length_ff <= 8'd0;
         bytes_left_ff <= 8'd0;
         emitted_count_ff <= 8'd0;
         integer_index_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         parse_phase_ff <= parse_phase_in;
         held_total_length_ff <= held_total_length_in;
         bytes_left_ff <= bytes_left_in;
         emitted_count_ff <= emitted_count_in;
         integer_index_ff <= integer_index_in;
         wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(n_push);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_ff + QUEUE_CNT_W'(n_push) - QUEUE_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (n_push == 2'd2) begin
         queue_ff[wr_ptr_nxt] <= res1;
      end
   end

endmodule
